// ----- src/nbg_pkg.sv -----
// Shared constants for the noise burst generator: register map, LCG terms, reset values.
package nbg_pkg;

    // Register map, word index on the configuration port
    localparam logic [2:0] REG_SEED   = 3'd0;
    localparam logic [2:0] REG_COEFF  = 3'd1;
    localparam logic [2:0] REG_DECAY  = 3'd2;
    localparam logic [2:0] REG_GAIN   = 3'd3;
    localparam logic [2:0] REG_LENGTH = 3'd4;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int LENGTH_W = 24;

    // LCG terms
    localparam int          LCG_MUL_W = 21;
    localparam logic [20:0] LCG_MUL   = 21'd1664525;
    localparam logic [31:0] LCG_ADD   = 32'd1013904223;

    // Reset values
    localparam logic [31:0] SEED_RESET  = 32'h9E3779B9;
    localparam logic [15:0] COEFF_RESET = 16'd8192;
    localparam logic [15:0] DECAY_RESET = 16'd65535;
    localparam logic [15:0] GAIN_RESET  = 16'd4096;
    localparam logic [16:0] UNITY_ENV   = 17'd65536;

    // Output saturation limits
    localparam logic [15:0] SAMPLE_MAX = 16'h7FFF;
    localparam logic [15:0] SAMPLE_MIN = 16'h8000;

endpackage

// ----- src/noise_burst_generator.sv -----
// Decaying lowpass-filtered LCG noise burst, one sample per accepted transfer.
// Sequence: a burst sample passes the states start, LCG step, filter start, filter,
//   product start, output product and output; an idle step (no burst running) gives
//   its zero result in the cycle after the transfer. No new transfer is taken until
//   the current burst sample, made by a chain of bit-serial multiplies, is loaded.
// Reset: asynchronous, active low; registers take their documented defaults.
module noise_burst_generator #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        restart,
    // output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [15:0]          sample,
    output logic                        last_sample,
    output logic                        active,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nbg_pkg::ADDR_W-1:0]  paddr,
    input  logic [nbg_pkg::DATA_W-1:0]  pwdata,
    output logic [nbg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    import nbg_pkg::*;

    localparam int LEN_W = (COUNT_WIDTH < LENGTH_W) ? COUNT_WIDTH : LENGTH_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_NOISE,
        S_FSTART,
        S_FILT,
        S_PSTART,
        S_PROD,
        S_OUT
    } state_t;

    // Configuration registers
    logic [31:0]      seed_reg;
    logic [15:0]      coeff_reg;
    logic [15:0]      decay_reg;
    logic [15:0]      gain_reg;
    logic [LEN_W-1:0] len_reg;

    // Burst state
    state_t                 state_reg;
    logic [31:0]            lcg_reg;
    logic [24:0]            f_reg;
    logic [16:0]            env_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic                   running_reg;
    logic                   res_last_reg;

    // Output registers
    logic        out_valid_reg;
    logic [15:0] sample_reg;
    logic        last_reg;
    logic        active_reg;

    // Multiplier hookup
    logic        lcg_done;
    logic [32:0] lcg_prod;
    logic        env_done;
    logic [32:0] env_prod;
    logic        ge_done;
    logic [32:0] ge_prod;
    logic        flt_done;
    logic [41:0] flt_prod;
    logic        out_done;
    logic [57:0] out_prod;

    logic                   cfg_write;
    logic                   in_accept;
    logic                   run_now;
    logic                   len_nonzero;
    logic [31:0]            lcg_next;
    logic [23:0]            noise;
    logic [25:0]            diff;
    logic [24:0]            f_next;
    logic [16:0]            env_next;
    logic [21:0]            prod_q;
    logic [15:0]            sat_sample;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic                   is_last;
    logic                   out_free;
    logic                   out_load;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= SEED_RESET;
            coeff_reg <= COEFF_RESET;
            decay_reg <= DECAY_RESET;
            gain_reg  <= GAIN_RESET;
            len_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_SEED:   seed_reg  <= pwdata;
                REG_COEFF:  coeff_reg <= pwdata[15:0];
                REG_DECAY:  decay_reg <= pwdata[15:0];
                REG_GAIN:   gain_reg  <= pwdata[15:0];
                REG_LENGTH: len_reg   <= pwdata[LEN_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_SEED:   prdata = seed_reg;
            REG_COEFF:  prdata = {16'd0, coeff_reg};
            REG_DECAY:  prdata = {16'd0, decay_reg};
            REG_GAIN:   prdata = {16'd0, gain_reg};
            REG_LENGTH: prdata = 32'(len_reg);
            default:    prdata = '0;
        endcase
    end

    // Serial multipliers: LCG step, envelope decay, gain*envelope, filter, output
    nbg_sermul #(
        .A_W(32), .B_W(LCG_MUL_W), .P_W(33), .A_SIGNED(1'b0), .B_SIGNED(1'b0)
    ) u_lcg_mul (
        .clk(clk), .rst_n(rst_n), .start(state_reg == S_START),
        .a(lcg_reg), .b(LCG_MUL), .done(lcg_done), .product(lcg_prod)
    );

    nbg_sermul #(
        .A_W(17), .B_W(16), .P_W(33), .A_SIGNED(1'b0), .B_SIGNED(1'b0)
    ) u_env_mul (
        .clk(clk), .rst_n(rst_n), .start(state_reg == S_START),
        .a(env_reg), .b(decay_reg), .done(env_done), .product(env_prod)
    );

    nbg_sermul #(
        .A_W(16), .B_W(17), .P_W(33), .A_SIGNED(1'b0), .B_SIGNED(1'b0)
    ) u_ge_mul (
        .clk(clk), .rst_n(rst_n), .start(state_reg == S_START),
        .a(gain_reg), .b(env_reg), .done(ge_done), .product(ge_prod)
    );

    nbg_sermul #(
        .A_W(26), .B_W(16), .P_W(42), .A_SIGNED(1'b1), .B_SIGNED(1'b0)
    ) u_flt_mul (
        .clk(clk), .rst_n(rst_n), .start(state_reg == S_FSTART),
        .a(diff), .b(coeff_reg), .done(flt_done), .product(flt_prod)
    );

    nbg_sermul #(
        .A_W(33), .B_W(25), .P_W(58), .A_SIGNED(1'b0), .B_SIGNED(1'b1)
    ) u_out_mul (
        .clk(clk), .rst_n(rst_n), .start(state_reg == S_PSTART),
        .a(ge_prod), .b(f_reg), .done(out_done), .product(out_prod)
    );

    // Datapath between multiplies
    always_comb
    begin
        lcg_next = lcg_prod[31:0] + LCG_ADD;
        // top 24 bits minus 2^23 is a flip of the top bit
        noise    = {~lcg_reg[31], lcg_reg[30:8]};
        diff     = {{2{noise[23]}}, noise} - {f_reg[24], f_reg};
        f_next   = 25'({f_reg[24], f_reg} + flt_prod[41:16]);
        env_next = env_prod[32:16];
        prod_q   = out_prod[57:36];
        // saturate to signed 16 bits
        if (prod_q[21:15] == {7{prod_q[21]}})
        begin
            sat_sample = prod_q[15:0];
        end
        else if (prod_q[21])
        begin
            sat_sample = SAMPLE_MIN;
        end
        else
        begin
            sat_sample = SAMPLE_MAX;
        end
        count_inc   = count_reg + 1'b1;
        is_last     = (count_inc == COUNT_WIDTH'(len_reg));
        len_nonzero = (len_reg != '0);
        run_now     = restart ? len_nonzero : running_reg;
    end

    // Handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign in_accept = in_valid && !in_stall;

    // Output register loads on an idle step or a finished burst sample
    assign out_load = (state_reg == S_OUT) ? out_free
                    : ((state_reg == S_IDLE) && in_accept && !run_now);

    // Sequencer, burst state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lcg_reg       <= SEED_RESET;
            f_reg         <= '0;
            env_reg       <= UNITY_ENV;
            count_reg     <= '0;
            running_reg   <= 1'b0;
            res_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
            last_reg      <= 1'b0;
            active_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (restart)
                        begin
                            lcg_reg     <= seed_reg;
                            f_reg       <= '0;
                            env_reg     <= UNITY_ENV;
                            count_reg   <= '0;
                            running_reg <= len_nonzero;
                        end
                        if (run_now)
                        begin
                            state_reg <= S_START;
                        end
                        else
                        begin
                            // idle step: zero result straight away
                            sample_reg    <= '0;
                            last_reg      <= 1'b0;
                            active_reg    <= 1'b0;
                        end
                    end
                end
                S_START:
                begin
                    state_reg <= S_NOISE;
                end
                S_NOISE:
                begin
                    // envelope and gain products finish before the LCG step
                    if (lcg_done)
                    begin
                        lcg_reg   <= lcg_next;
                        state_reg <= S_FSTART;
                    end
                end
                S_FSTART:
                begin
                    state_reg <= S_FILT;
                end
                S_FILT:
                begin
                    if (flt_done)
                    begin
                        f_reg     <= f_next;
                        state_reg <= S_PSTART;
                    end
                end
                S_PSTART:
                begin
                    state_reg <= S_PROD;
                end
                S_PROD:
                begin
                    if (out_done)
                    begin
                        env_reg      <= env_next;
                        count_reg    <= count_inc;
                        res_last_reg <= is_last;
                        if (is_last)
                        begin
                            running_reg <= 1'b0;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        sample_reg    <= sat_sample;
                        last_reg      <= res_last_reg;
                        active_reg    <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample      = sample_reg;
    assign last_sample = last_reg;
    assign active      = active_reg;

`ifndef SYNTH
    // the final sample of a burst is always a burst sample
    a_last_is_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> active_reg)
        else $error("last_sample without active");

    // idle steps carry a zero sample
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !active_reg |-> (sample_reg == '0) && !last_reg)
        else $error("idle result not zero");

    // the LCG multiply only ends while the sequencer waits for it
    a_lcg_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        lcg_done |-> (state_reg == S_NOISE) && !env_done && !ge_done)
        else $error("LCG product out of sequence");

    // filter and output multiplies finish in their own states
    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        (!flt_done || (state_reg == S_FILT)) && (!out_done || (state_reg == S_PROD)))
        else $error("filter or output product out of sequence");
`endif

endmodule

// ----- src/nbg_sermul.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module nbg_sermul #(
    parameter int A_W      = 16,
    parameter int B_W      = 16,
    parameter int P_W      = 33,
    parameter bit A_SIGNED = 1'b0,
    parameter bit B_SIGNED = 1'b0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           done,
    output logic [P_W-1:0] product
);

    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [P_W-1:0]   acc_reg;
    logic [P_W-1:0]   mcand_reg;
    logic [B_W-1:0]   mplier_reg;

    logic [P_W-1:0]   a_ext;
    logic [P_W-1:0]   addend;
    logic [P_W-1:0]   acc_next;
    logic             last_step;

    // Operand extension and one partial product per cycle
    always_comb
    begin
        a_ext     = {{(P_W-A_W){A_SIGNED & a[A_W-1]}}, a};
        last_step = (cnt_reg == CNT_W'(B_W - 1));
        addend    = mplier_reg[0] ? mcand_reg : '0;
        // top multiplier bit of a signed operand carries negative weight
        if (B_SIGNED && last_step)
        begin
            acc_next = acc_reg - addend;
        end
        else
        begin
            acc_next = acc_reg + addend;
        end
    end

    // Control: step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: accumulator and shifting operands
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= a_ext;
            mplier_reg <= b;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_next;
            mcand_reg  <= {mcand_reg[P_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[B_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
